// ----- design/tssc_pkg.sv -----
// Package for the temperature sensor scratchpad checker.
// Holds payload types, scratchpad/CRC constants and the CRC-8 byte function.
// No dependencies.
package tssc_pkg;

   localparam logic [7:0]  CRC_POLY     = 8'h8C;
   localparam logic [3:0]  CRC_INDEX    = 4'd8;
   localparam logic [3:0]  IDLE_COUNT   = 4'd9;
   localparam logic [10:0] TEMP_MASK    = 11'h7FF;
   localparam logic [15:0] DEC_RECIP    = 16'd205;
   localparam int          DEC_SHIFT    = 11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic       crc_ok;
      logic [7:0] degrees;
      logic [3:0] tens_digit;
      logic [3:0] units_digit;
   } rsp_payload_type;

   // Dallas/Maxim CRC-8, LSB first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       mix;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ data[k];
         c   = {1'b0, c[7:1]};
         if (mix) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

// ----- design/tssc_if.sv -----
// Valid/ready channel interfaces for the scratchpad checker.
// Depends on tssc_pkg for the payload types.
interface tssc_req_if;
   import tssc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tssc_rsp_if;
   import tssc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/temp_sensor_scratchpad_checker.sv -----
// Flow: each accepted byte is registered in the input register; the CRC byte waits
// there until the result register is free, where the result then turns valid.
// Throughput: one scratchpad byte per cycle while no CRC byte waits on a stalled
// result, set by the input register feeding the byte-wide CRC and temperature
// logic; one result per nine-byte frame. Reset: synchronous, active high;
// clears stage valids, count, CRC and bytes. Depends on tssc_pkg and tssc_if.
module temp_sensor_scratchpad_checker (
   input  logic         clock,
   input  logic         reset,
   tssc_req_if.sink     req_if,
   tssc_rsp_if.source   rsp_if
);
   import tssc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic [3:0]      count_ff, count_in;
   logic [7:0]      crc_ff, crc_in;
   logic [7:0]      low_ff, low_in;
   logic [7:0]      high_ff, high_in;

   logic [3:0]  cnt;
   logic [7:0]  crc_cur;
   logic        has_result;
   logic        out_free;
   logic        consume;
   logic [10:0] raw;
   logic [7:0]  half_deg;
   logic [7:0]  deg;
   logic [15:0] prod;
   logic [3:0]  tens;
   logic [7:0]  tens_x10;
   logic [7:0]  units_w;
   logic        match;

   assign cnt        = in_data_ff.frame_start ? 4'd0 : count_ff;
   assign crc_cur    = in_data_ff.frame_start ? 8'd0 : crc_ff;
   assign has_result = (cnt == CRC_INDEX);
   assign out_free   = !out_valid_ff || rsp_if.ready;
   assign consume    = in_valid_ff && (out_free || !has_result);
   assign req_if.ready = !in_valid_ff || consume;

   assign raw      = {high_ff[2:0], low_ff} & TEMP_MASK;
   assign half_deg = raw[10:3];
   assign deg      = {1'b0, half_deg[7:1]} + {7'd0, half_deg[0]};
   assign prod     = {8'd0, deg} * DEC_RECIP;
   assign tens     = prod[DEC_SHIFT +: 4];
   assign tens_x10 = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
   assign units_w  = deg - tens_x10;
   assign match    = (in_data_ff.data_byte == crc_cur);

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      in_valid_in  = in_valid_ff && !consume;
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
      end
      if (consume) begin
         if (cnt < CRC_INDEX) begin
            if (cnt == 4'd0) begin
               low_in = in_data_ff.data_byte;
            end
            if (cnt == 4'd1) begin
               high_in = in_data_ff.data_byte;
            end
            crc_in   = crc8_byte(crc_cur, in_data_ff.data_byte);
            count_in = cnt + 4'd1;
         end else if (has_result) begin
            crc_in       = crc_cur;
            count_in     = IDLE_COUNT;
            out_valid_in = 1'b1;
            out_data_in.crc_ok      = match;
            out_data_in.degrees     = match ? deg : 8'd0;
            out_data_in.tens_digit  = match ? tens : 4'd0;
            out_data_in.units_digit = match ? units_w[3:0] : 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= 4'd0;
         crc_ff       <= 8'd0;
         low_ff       <= 8'd0;
         high_ff      <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_data_ff <= req_if.payload;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule

// ----- design/tssc_checker.sv -----
// Port-level assertions for the scratchpad checker, bound to the top level.
// Depends on tssc_pkg and temp_sensor_scratchpad_checker.
module tssc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tssc_pkg::rsp_payload_type rsp_payload
);
   import tssc_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.crc_ok |-> rsp_payload.degrees == 8'd0 &&
      rsp_payload.tens_digit == 4'd0 && rsp_payload.units_digit == 4'd0)
      else $error("nonzero temperature on CRC mismatch");

   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.units_digit <= 4'd9 &&
      ({4'd0, rsp_payload.tens_digit} * 8'd10 + {4'd0, rsp_payload.units_digit})
      == rsp_payload.degrees)
      else $error("decimal digits disagree with degrees");

endmodule

bind temp_sensor_scratchpad_checker tssc_checker u_tssc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
